[design/rmoa_pkg.sv]
// Package for the rotation-matrix-to-angles block: widths, CORDIC table, helpers.
// No dependencies.
package rmoa_pkg;

  localparam int unsigned DefStages   = 16;
  localparam int unsigned TabLen      = 24;
  localparam int unsigned SqrtStages  = 24;  // one root bit per stage
  localparam int unsigned XW          = 47;  // CORDIC x/y datapath width
  localparam int unsigned ZW          = 34;  // angle accumulator width, pi/2^31 units

  localparam logic signed [ZW-1:0] AngHalfPi = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] AngPi     = ZW'(64'sd2147483648);

  typedef enum logic [2:0] {
    BR_POS, BR_NEG, BR_ZPOS, BR_ZNEG, BR_LOCK
  } branch_e;

  typedef struct packed {
    logic signed [15:0] m00, m01, m10, m11, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    logic [15:0]        alpha;
    logic signed [15:0] beta;
    logic signed [15:0] gamma;
  } ang_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(536870912);   1: r = ZW'(316933406);  2: r = ZW'(167458907);
      3: r = ZW'(85004756);    4: r = ZW'(42667331);   5: r = ZW'(21354465);
      6: r = ZW'(10679838);    7: r = ZW'(5340245);    8: r = ZW'(2670163);
      9: r = ZW'(1335087);     10: r = ZW'(667544);    11: r = ZW'(333772);
      12: r = ZW'(166886);     13: r = ZW'(83443);     14: r = ZW'(41722);
      15: r = ZW'(20861);      16: r = ZW'(10430);     17: r = ZW'(5215);
      18: r = ZW'(2608);       19: r = ZW'(1304);      20: r = ZW'(652);
      21: r = ZW'(326);        22: r = ZW'(163);       23: r = ZW'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up to pi/2^15 units, modulo 2^16
  function automatic logic [15:0] to_out(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + ZW'(32768);
    return t[31:16];
  endfunction

endpackage

[design/rmoa_if.sv]
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface rmoa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/rmoa_sqrt.sv]
// Pipelined integer square root of 2^46 - (256*s)^2, one result bit per stage.
// Uses rmoa_pkg.
module rmoa_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic signed [15:0] s_i,
  output logic [23:0] root_o   // registered after the input and root stages
);
  import rmoa_pkg::*;
  localparam int unsigned N = SqrtStages;
  logic [47:0] n_q [N+1];
  logic [23:0] r_q [N+1];
  logic signed [31:0] sw;
  logic [31:0] sq;

  always_comb begin
    sw = 32'(s_i);
    sq = 32'(sw * sw);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= (48'd1 << 46) - {sq, 16'd0};
      r_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int unsigned Sh  = 46 - 2*k;
    localparam int unsigned RSh = 48 - 2*k;
    logic [47:0] n_d, r_w;
    logic [47:0] bitv;
    always_comb begin
      bitv = 48'd1 << Sh;
      r_w  = {24'd0, r_q[k]} << RSh;
      n_d  = n_q[k];
      // restoring form: test candidate 2*root*bit + bit^2
      if (n_q[k] >= r_w + bitv) n_d = n_q[k] - (r_w + bitv);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1] <= n_d;
        r_q[k+1] <= (n_q[k] >= r_w + bitv) ? {r_q[k][22:0], 1'b1} : {r_q[k][22:0], 1'b0};
      end
    end
  end

  assign root_o = r_q[N];
endmodule

[design/rmoa_cordic.sv]
// Pipelined vectoring CORDIC atan2, one micro-rotation per stage, plus pre-rotation stage.
// Uses rmoa_pkg.
module rmoa_cordic #(
  parameter int unsigned Stages = rmoa_pkg::DefStages
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [rmoa_pkg::XW-1:0] x_i,
  input  logic signed [rmoa_pkg::XW-1:0] y_i,
  output logic signed [rmoa_pkg::ZW-1:0] z_o   // registered after the pre-rotation and micro-rotation stages
);
  import rmoa_pkg::*;
  logic signed [XW-1:0] x_q [Stages+1];
  logic signed [XW-1:0] y_q [Stages+1];
  logic signed [ZW-1:0] z_q [Stages+1];
  logic                 zero_q [Stages+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0 && y_i >= 0) begin
        x_q[0] <= y_i; y_q[0] <= -x_i; z_q[0] <= AngHalfPi;
      end else if (x_i < 0) begin
        x_q[0] <= -y_i; y_q[0] <= x_i; z_q[0] <= -AngHalfPi;
      end else begin
        x_q[0] <= x_i; y_q[0] <= y_i; z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_rot
    logic signed [ZW-1:0] a;
    assign a = (i < TabLen) ? atan_tab(i) : '0;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (i >= TabLen) begin
          x_q[i+1] <= x_q[i]; y_q[i+1] <= y_q[i]; z_q[i+1] <= z_q[i];
        end else if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + a;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - a;
        end
      end
    end
  end

  assign z_o = zero_q[Stages] ? '0 : z_q[Stages];
endmodule

[design/rotation_matrix_to_orientation_angles.sv]
// Top level: Z-X-Y orientation angles from a Q1.15 rotation matrix.
// Uses rmoa_pkg, rmoa_if, rmoa_sqrt, rmoa_cordic.
//
//  channel | dir | payload
//  in_if   | in  | rmoa_pkg::mat_t (m00..m22)
//  out_if  | out | rmoa_pkg::ang_t (alpha, beta, gamma)
//
// One item per cycle unless the output is held. Stages: one input stage,
// the square-root input register and 24 square-root stages (on every path, to
// keep items aligned), the CORDIC pre-rotation plus CORDIC_STAGES
// micro-rotations, and a final stage.
// The whole pipe advances on a single enable: when the output holds a
// waiting item the pipe freezes; valid bits move with the data.
// Reset clears only the valid bits.
module rotation_matrix_to_orientation_angles #(
  parameter int unsigned CORDIC_STAGES = rmoa_pkg::DefStages
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmoa_if.sink   in_if,
  rmoa_if.source out_if
);
  import rmoa_pkg::*;
  localparam int unsigned SqD = SqrtStages + 1;
  localparam int unsigned CoD = CORDIC_STAGES + 1;
  localparam int unsigned Lat = 1 + SqD + CoD + 1;

  logic en;
  logic [Lat-1:0] v_q;

  // pipe moves unless the last stage holds an item not yet taken
  assign en = !v_q[Lat-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Lat-2:0], in_if.valid};
  end

  // stage 0: branch decode and operand selection
  mat_t    m;
  branch_e br_d, br_q;
  logic signed [16:0] ay_d, ax_d, gy_d, gx_d;
  logic signed [16:0] ay_q, ax_q, gy_q, gx_q;
  logic signed [15:0] s_q;
  logic lockpos_q;
  assign m = in_if.data;

  always_comb begin
    if (m.m22 > 0)       br_d = BR_POS;
    else if (m.m22 < 0)  br_d = BR_NEG;
    else if (m.m20 > 0)  br_d = BR_ZPOS;
    else if (m.m20 < 0)  br_d = BR_ZNEG;
    else                 br_d = BR_LOCK;
    gy_d = -17'(m.m20); gx_d = 17'(m.m22);
    unique case (br_d)
      BR_POS, BR_ZPOS: begin ay_d = -17'(m.m01); ax_d = 17'(m.m11); end
      BR_NEG, BR_ZNEG: begin
        ay_d = 17'(m.m01); ax_d = -17'(m.m11);
        gy_d = 17'(m.m20); gx_d = -17'(m.m22);
      end
      BR_LOCK: begin ay_d = 17'(m.m10); ax_d = 17'(m.m00); end
      default: begin ay_d = '0; ax_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      br_q <= br_d; ay_q <= ay_d; ax_q <= ax_d; gy_q <= gy_d; gx_q <= gx_d;
      s_q <= m.m21; lockpos_q <= m.m21 > 0;
    end
  end

  // square root for asin; other operands wait alongside
  logic [23:0] root;
  rmoa_sqrt u_sqrt (.clk_i, .en_i(en), .s_i(s_q), .root_o(root));

  logic signed [16:0] ay_l [SqD+1], ax_l [SqD+1], gy_l [SqD+1], gx_l [SqD+1];
  logic signed [15:0] s_l [SqD+1];
  branch_e br_l [SqD+1];
  logic lk_l [SqD+1];
  assign ay_l[0] = ay_q; assign ax_l[0] = ax_q; assign gy_l[0] = gy_q;
  assign gx_l[0] = gx_q; assign s_l[0] = s_q; assign br_l[0] = br_q;
  assign lk_l[0] = lockpos_q;
  for (genvar k = 0; k < SqD; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        ay_l[k+1] <= ay_l[k]; ax_l[k+1] <= ax_l[k]; gy_l[k+1] <= gy_l[k];
        gx_l[k+1] <= gx_l[k]; s_l[k+1] <= s_l[k]; br_l[k+1] <= br_l[k];
        lk_l[k+1] <= lk_l[k];
      end
    end
  end

  // three CORDIC lanes, operands prescaled by 2^20; the asin sine also
  // carries the 2^8 that lifts it to Q1.23
  logic signed [ZW-1:0] za, zb, zg;
  rmoa_cordic #(.Stages(CORDIC_STAGES)) u_ca (.clk_i, .en_i(en),
    .x_i(XW'(ax_l[SqD]) <<< 20), .y_i(XW'(ay_l[SqD]) <<< 20), .z_o(za));
  rmoa_cordic #(.Stages(CORDIC_STAGES)) u_cb (.clk_i, .en_i(en),
    .x_i(XW'({1'b0, root}) <<< 20), .y_i(XW'(s_l[SqD]) <<< 28), .z_o(zb));
  rmoa_cordic #(.Stages(CORDIC_STAGES)) u_cg (.clk_i, .en_i(en),
    .x_i(XW'(gx_l[SqD]) <<< 20), .y_i(XW'(gy_l[SqD]) <<< 20), .z_o(zg));

  branch_e br_c [CoD+1];
  logic lk_c [CoD+1];
  assign br_c[0] = br_l[SqD]; assign lk_c[0] = lk_l[SqD];
  for (genvar k = 0; k < CoD; k++) begin : g_cdly
    always_ff @(posedge clk_i) begin
      if (en) begin br_c[k+1] <= br_c[k]; lk_c[k+1] <= lk_c[k]; end
    end
  end

  // final stage: fold, wrap, round
  ang_t res_d, res_q;
  logic signed [ZW-1:0] a_f, b_f, g_f, nb;
  always_comb begin
    a_f = za; b_f = zb; g_f = zg; nb = -zb;
    unique case (br_c[CoD])
      BR_POS:  ;
      BR_NEG:  b_f = nb + ((nb >= 0) ? -AngPi : AngPi);
      BR_ZPOS: g_f = -AngHalfPi;
      BR_ZNEG: begin b_f = nb + ((nb >= 0) ? -AngPi : AngPi); g_f = -AngHalfPi; end
      BR_LOCK: begin b_f = lk_c[CoD] ? AngHalfPi : -AngHalfPi; g_f = '0; end
      default: ;
    endcase
    // adding 2pi is invisible modulo 2^16 after rounding
    res_d.alpha = to_out(a_f);
    res_d.beta  = to_out(b_f);
    res_d.gamma = to_out(g_f);
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_if.valid = v_q[Lat-1];
  assign out_if.data  = res_q;
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_orientation_angles: a local predictor of the Z-X-Y angles,
// directed, rotation-based and noise items, random stalls on both channels.
// Depends on rmoa_pkg, rmoa_if and the block's RTL.
module testbench;
  import rmoa_pkg::*;

  localparam int          STAGES     = 16;   // default CORDIC depth of the block
  localparam int          LATENCY    = STAGES + 28;
  localparam longint      A_PI       = 64'sd2147483648;
  localparam longint      A_HALF_PI  = 64'sd1073741824;
  localparam longint      A_TWO_PI   = 64'sd4294967296;
  localparam longint      GAIN_SHIFT = 64'sd1048576;  // pre-scale of CORDIC operands

  // atan(2^-i) in units of pi/2^31
  localparam longint ATAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic clk_i;
  logic rst_ni;

  rmoa_if #(.T(mat_t)) mat_ch ();
  rmoa_if #(.T(ang_t)) ang_ch ();

  rotation_matrix_to_orientation_angles dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (mat_ch),
    .out_if (ang_ch)
  );

  // Angles still owed by the block, oldest first.
  ang_t pending_angles[$];
  int   errors = 0;

  // Sender and receiver idling knobs.
  int   gap_pct   = 30;   // chance that a gap precedes an item
  int   stall_pct = 30;   // chance that ready drops for a cycle
  int   hold_left = 0;    // long receiver hold, counted down by the ready process

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  // Vectoring CORDIC, result in pi/2^31 units, range (-pi, pi].
  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * GAIN_SHIFT;
    y = y * GAIN_SHIFT;
    // left half plane: pre-rotate by +/- pi/2
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = A_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -A_HALF_PI;
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 46;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // asin of a Q1.15 value as atan2(s, sqrt(1 - s^2)) in Q1.23
  function automatic longint vec_asin(longint s);
    longint wide;
    wide = s * 256;
    return vec_atan2(wide, int_sqrt(longint'(64'd1 << 46) - wide * wide));
  endfunction

  // cos(beta) negative: negate and move into [-pi, pi)
  function automatic longint flip_beta(longint a);
    longint b;
    b = -a;
    return b + ((b >= 0) ? -A_PI : A_PI);
  endfunction

  function automatic logic [15:0] binary_angle(longint z);
    longint t;
    t = (z + 32768) >>> 16;
    return t[15:0];
  endfunction

  function automatic ang_t predict_angles(mat_t m);
    longint r0, r1, r3, r4, r6, r7, r8, a, b, g;
    ang_t   res;
    r0 = m.m00; r1 = m.m01; r3 = m.m10; r4 = m.m11;
    r6 = m.m20; r7 = m.m21; r8 = m.m22;
    if (r8 > 0) begin
      a = vec_atan2(-r1, r4);
      b = vec_asin(r7);
      g = vec_atan2(-r6, r8);
    end else if (r8 < 0) begin
      a = vec_atan2(r1, -r4);
      b = flip_beta(vec_asin(r7));
      g = vec_atan2(r6, -r8);
    end else if (r6 > 0) begin
      a = vec_atan2(-r1, r4);
      b = vec_asin(r7);
      g = -A_HALF_PI;
    end else if (r6 < 0) begin
      a = vec_atan2(r1, -r4);
      b = flip_beta(vec_asin(r7));
      g = -A_HALF_PI;
    end else begin
      // gimbal lock: only alpha is observable
      a = vec_atan2(r3, r0);
      b = (r7 > 0) ? A_HALF_PI : -A_HALF_PI;
      g = 0;
    end
    if (a < 0) a += A_TWO_PI;
    res.alpha = binary_angle(a);
    res.beta  = binary_angle(b);
    res.gamma = binary_angle(g);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and checker
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r >= gap_pct) return 0;
    if (r < 2) return $urandom_range(20, 60);  // rare long gap
    return $urandom_range(1, 4);
  endfunction

  // Offer one matrix and wait until the block takes it.
  task automatic send_matrix(mat_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      mat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mat_ch.valid <= 1'b1;
    mat_ch.data  <= m;
    do @(posedge clk_i); while (!mat_ch.ready);
    pending_angles.push_back(predict_angles(m));
  endtask

  // Receiver: random stalls, plus the long hold when asked for.
  initial begin
    ang_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        ang_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        ang_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    ang_t want;
    if (rst_ni && ang_ch.valid && ang_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected item alpha=%0d beta=%0d gamma=%0d", $realtime,
                 ang_ch.data.alpha, ang_ch.data.beta, ang_ch.data.gamma);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (ang_ch.data.alpha !== want.alpha) begin
          $display("%0t: alpha expected %0d actual %0d", $realtime, want.alpha,
                   ang_ch.data.alpha);
          errors++;
        end
        if (ang_ch.data.beta !== want.beta) begin
          $display("%0t: beta expected %0d actual %0d", $realtime, want.beta,
                   ang_ch.data.beta);
          errors++;
        end
        if (ang_ch.data.gamma !== want.gamma) begin
          $display("%0t: gamma expected %0d actual %0d", $realtime, want.gamma,
                   ang_ch.data.gamma);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic mat_t make_mat(int a00, int a01, int a10, int a11, int a20, int a21,
                                    int a22);
    mat_t m;
    m.m00 = 16'(a00); m.m01 = 16'(a01); m.m10 = 16'(a10); m.m11 = 16'(a11);
    m.m20 = 16'(a20); m.m21 = 16'(a21); m.m22 = 16'(a22);
    return m;
  endfunction

  function automatic logic signed [15:0] to_q15(real v);
    int q;
    q = int'(v * 32767.0);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // R = Rz(a) * Rx(b) * Ry(g), angles given as binary angles
  function automatic mat_t rotation(int ba, int bb, int bg);
    real a, b, g, ca, sa, cb, sb, cg, sg;
    mat_t m;
    a = ba * 3.14159265358979 / 32768.0;
    b = bb * 3.14159265358979 / 32768.0;
    g = bg * 3.14159265358979 / 32768.0;
    ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cg = $cos(g); sg = $sin(g);
    m.m00 = to_q15(ca * cg - sa * sb * sg);
    m.m01 = to_q15(-sa * cb);
    m.m10 = to_q15(sa * cg + ca * sb * sg);
    m.m11 = to_q15(ca * cb);
    m.m20 = to_q15(-cb * sg);
    m.m21 = to_q15(sb);
    m.m22 = to_q15(cb * cg);
    return m;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    return 16'($urandom);
  endfunction

  // Extremes, each branch and the rounding corners.
  task automatic test_directed();
    send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0));                 // lock, zero atan2
    send_matrix(make_mat(0, 0, 0, 0, 0, 1, 0));                 // lock, beta +pi/2
    send_matrix(make_mat(-32768, 0, 0, 0, 0, -5, 0));           // lock, alpha = pi
    send_matrix(make_mat(0, 0, -32768, 0, 0, 32767, 0));        // lock, alpha wraps up
    send_matrix(make_mat(32767, -32768, 32767, -32768, 0, 0, 0));
    send_matrix(make_mat(32767, 0, 0, 32767, 0, 0, 32767));     // identity
    send_matrix(make_mat(32767, 0, 0, -32768, 0, 0, -32768));   // m22 negative
    send_matrix(make_mat(0, 100, 0, 32767, 32767, 0, 0));       // m22 zero, m20 positive
    send_matrix(make_mat(0, 100, 0, 32767, -32768, 0, 0));      // m22 zero, m20 negative
    send_matrix(make_mat(0, 0, 0, 32767, 0, 32767, 1));         // asin near +1
    send_matrix(make_mat(0, 0, 0, 32767, 0, -32768, 1));        // asin of -1
    send_matrix(make_mat(0, 0, 0, -32768, 0, -32768, -1));
    send_matrix(make_mat(0, 0, 0, 32767, 0, 0, -100));          // beta from -0 folds to -pi
    send_matrix(make_mat(0, 0, 0, 32767, 0, 1, -100));          // beta rounds to +pi, wraps
    send_matrix(make_mat(0, 1, 0, 32767, 0, 0, 32767));         // tiny negative alpha
    send_matrix(make_mat(0, 1, 0, 0, 0, 0, 32767));             // atan2 on the axis
    send_matrix(make_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(make_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_matrix(make_mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768));
    send_matrix(make_mat(32767, -32768, 32767, -32768, 32767, -32768, 32767));
    send_matrix(make_mat(0, 0, 0, 0, 1, 0, 0));
    send_matrix(make_mat(0, 0, 0, 0, -1, 0, 0));
  endtask

  // Proper rotations with random angles, some placed at gimbal lock or at gamma = +/-pi/2.
  task automatic test_rotations(int count);
    int ba, bb, bg, r;
    for (int n = 0; n < count; n++) begin
      ba = $urandom_range(0, 65535);
      bb = $urandom_range(0, 32768) - 16384;
      bg = $urandom_range(0, 65535) - 32768;
      r  = $urandom_range(0, 9);
      if (r == 0) bb = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      if (r == 1) bg = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      send_matrix(rotation(ba, bb, bg));
    end
  endtask

  // Arbitrary element values; m22 and m20 forced to zero, m21 to an extreme, now and then.
  task automatic test_noise(int count);
    mat_t m;
    int   r;
    for (int n = 0; n < count; n++) begin
      m = make_mat(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                   rand_elem(), rand_elem());
      r = $urandom_range(0, 9);
      if (r < 3) m.m22 = 0;
      if (r < 1) m.m20 = 0;
      if (r == 9) m.m21 = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      send_matrix(m);
    end
  endtask

  // Back to back, no stalls anywhere.
  task automatic test_full_rate(int count);
    gap_pct   = 0;
    stall_pct = 0;
    test_rotations(count);
    gap_pct   = 30;
    stall_pct = 30;
  endtask

  // Receiver holds off while the sender keeps offering: the pipe fills and backs up.
  task automatic test_backpressure(int count);
    gap_pct   = 0;
    hold_left = 3 * LATENCY;
    test_noise(count);
    gap_pct   = 30;
  endtask

  initial begin
    rst_ni       = 1'b0;
    mat_ch.valid = 1'b0;
    mat_ch.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rotations(550);
    test_full_rate(200);
    test_backpressure(100);
    test_noise(500);
    gap_pct   = 70;
    stall_pct = 70;
    test_rotations(80);

    mat_ch.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("rotation_matrix_to_orientation_angles verification clean");
    end else begin
      $display("rotation_matrix_to_orientation_angles verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("rotation_matrix_to_orientation_angles verification failed");
    $finish;
  end

endmodule

[sim.f]
design/rmoa_pkg.sv
design/rmoa_if.sv
design/rmoa_sqrt.sv
design/rmoa_cordic.sv
design/rotation_matrix_to_orientation_angles.sv
tb/testbench.sv
